FILE: src/lik_pkg.sv
package lik_pkg;

  // Port formats
  localparam int COORD_W    = 16;
  localparam int ANG_W      = 16;
  localparam int ANGLE_FRAC = 13;
  localparam int LEN_W      = 14;
  localparam int CFG_IDX_W  = 2;

  // Internal angle format: radians with Q_FRAC fraction bits
  localparam int Q_FRAC    = 30;
  localparam int OUT_SHIFT = Q_FRAC - ANGLE_FRAC;
  localparam int ACC_W     = 32;
  localparam int WIDE_W    = 34;

  // Square-root cell chain: two radicand bits per cell
  localparam int SQ_IN_W  = 60;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  localparam int SQ_STEPS = SQ_IN_W / 2;

  // Vectoring angle unit
  localparam int CORDIC_STAGES = 16;
  localparam int STG_W         = 5;
  localparam int VIN_W         = 45;
  localparam int VEC_W         = 44;
  localparam int NORM_BIT      = 41;
  localparam int BL_W          = 6;
  localparam int VEC_LAT       = 2 + CORDIC_STAGES;

  localparam logic signed [WIDE_W-1:0] PI_Q30 = 34'sd3373259426;

  // Register reset values, 1/16 mm
  localparam logic [LEN_W-1:0]        HK_RST = 14'd800;
  localparam logic [LEN_W-1:0]        KF_RST = 14'd1360;
  localparam logic [LEN_W-1:0]        FE_RST = 14'd880;
  localparam logic signed [LEN_W-1:0] KO_RST = -14'sd224;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIP_KNEE  = 2'd0,
    REG_KNEE_FOOT = 2'd1,
    REG_FOOT_TIP  = 2'd2,
    REG_KNEE_OFS  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] hip_angle;
    logic signed [ANG_W-1:0] knee_angle;
    logic signed [ANG_W-1:0] foot_angle;
    logic                    solved;
  } res_t;

  // atan(2^-i) in Q30, truncated (entries 27 to 30 rounded)
  function automatic logic signed [ACC_W-1:0] atan_q30(input logic [STG_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:  v = 32'sh3243F6A8;
      5'd1:  v = 32'sh1DAC6705;
      5'd2:  v = 32'sh0FADBAFC;
      5'd3:  v = 32'sh07F56EA6;
      5'd4:  v = 32'sh03FEAB76;
      5'd5:  v = 32'sh01FFD55B;
      5'd6:  v = 32'sh00FFFAAA;
      5'd7:  v = 32'sh007FFF55;
      5'd8:  v = 32'sh003FFFEA;
      5'd9:  v = 32'sh001FFFFD;
      5'd10: v = 32'sh000FFFFF;
      5'd11: v = 32'sh0007FFFF;
      5'd12: v = 32'sh0003FFFF;
      5'd13: v = 32'sh0001FFFF;
      5'd14: v = 32'sh0000FFFF;
      5'd15: v = 32'sh00007FFF;
      5'd16: v = 32'sh00003FFF;
      5'd17: v = 32'sh00001FFF;
      5'd18: v = 32'sh00000FFF;
      5'd19: v = 32'sh000007FF;
      5'd20: v = 32'sh000003FF;
      5'd21: v = 32'sh000001FF;
      5'd22: v = 32'sh000000FF;
      5'd23: v = 32'sh0000007F;
      5'd24: v = 32'sh0000003F;
      5'd25: v = 32'sh0000001F;
      5'd26: v = 32'sh0000000F;
      5'd27: v = 32'sh00000008;
      5'd28: v = 32'sh00000004;
      5'd29: v = 32'sh00000002;
      5'd30: v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round half away from zero to the port format, saturate
  function automatic logic signed [ANG_W-1:0] to_out(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-1:0]       mag;
    logic [WIDE_W-1:0]       r;
    logic signed [ANG_W-1:0] res;
    mag = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    r   = (mag + (WIDE_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (!v[WIDE_W-1]) begin
      if (r > WIDE_W'({1'b0, {(ANG_W-1){1'b1}}})) res = {1'b0, {(ANG_W-1){1'b1}}};
      else res = r[ANG_W-1:0];
    end else begin
      if (r >= (WIDE_W'(1) << (ANG_W - 1))) res = {1'b1, {(ANG_W-1){1'b0}}};
      else res = -$signed(r[ANG_W-1:0]);
    end
    return res;
  endfunction

endpackage

FILE: src/lik_if.sv
interface lik_pnt_if;
  logic                               valid;
  logic                               ready;
  logic signed [lik_pkg::COORD_W-1:0] x_pos;
  logic signed [lik_pkg::COORD_W-1:0] y_pos;
  logic signed [lik_pkg::COORD_W-1:0] z_pos;
  modport source(output valid, x_pos, y_pos, z_pos, input ready);
  modport sink(input valid, x_pos, y_pos, z_pos, output ready);
endinterface

interface lik_ang_if;
  logic                             valid;
  logic                             ready;
  logic signed [lik_pkg::ANG_W-1:0] hip_angle;
  logic signed [lik_pkg::ANG_W-1:0] knee_angle;
  logic signed [lik_pkg::ANG_W-1:0] foot_angle;
  logic                             solved;
  modport source(output valid, hip_angle, knee_angle, foot_angle, solved, input ready);
  modport sink(input valid, hip_angle, knee_angle, foot_angle, solved, output ready);
endinterface

interface lik_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lik_pkg::CFG_IDX_W-1:0]      index;
  logic [lik_pkg::LEN_W-1:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/lik_sqrt_cell.sv
module lik_sqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [lik_pkg::SQ_IN_W-1:0]    rad_in,
  input  logic [lik_pkg::SQ_OUT_W-1:0]   root_in,
  input  logic [lik_pkg::SQ_REM_W-1:0]   rem_in,
  output logic [lik_pkg::SQ_IN_W-1:0]    rad_out,
  output logic [lik_pkg::SQ_OUT_W-1:0]   root_out,
  output logic [lik_pkg::SQ_REM_W-1:0]   rem_out
);

  logic [lik_pkg::SQ_REM_W-1:0] rem_sh;
  logic [lik_pkg::SQ_REM_W-1:0] trial;
  logic                         ge;

  // bring down the next two radicand bits, try root*4+1
  assign rem_sh = {rem_in[lik_pkg::SQ_REM_W-3:0], rad_in[lik_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_in, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= rad_in << 2;
      root_out <= {root_in[lik_pkg::SQ_OUT_W-2:0], ge};
      rem_out  <= ge ? rem_sh - trial : rem_sh;
    end
  end

endmodule

FILE: src/lik_isqrt.sv
module lik_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lik_pkg::SQ_IN_W-1:0]  rad,
  output logic [lik_pkg::SQ_OUT_W-1:0] root
);

  logic [lik_pkg::SQ_IN_W-1:0]  rad_w  [lik_pkg::SQ_STEPS+1];
  logic [lik_pkg::SQ_OUT_W-1:0] root_w [lik_pkg::SQ_STEPS+1];
  logic [lik_pkg::SQ_REM_W-1:0] rem_w  [lik_pkg::SQ_STEPS+1];

  assign rad_w[0]  = rad;
  assign root_w[0] = '0;
  assign rem_w[0]  = '0;

  genvar g;
  for (g = 0; g < lik_pkg::SQ_STEPS; g++) begin : g_step
    lik_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (rad_w[g]),
      .root_in  (root_w[g]),
      .rem_in   (rem_w[g]),
      .rad_out  (rad_w[g+1]),
      .root_out (root_w[g+1]),
      .rem_out  (rem_w[g+1])
    );
  end

  assign root = root_w[lik_pkg::SQ_STEPS];

endmodule

FILE: src/lik_cordic_cell.sv
module lik_cordic_cell (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lik_pkg::STG_W-1:0]         stage,
  input  logic signed [lik_pkg::VEC_W-1:0]  x_in,
  input  logic signed [lik_pkg::VEC_W-1:0]  y_in,
  input  logic signed [lik_pkg::ACC_W-1:0]  a_in,
  output logic signed [lik_pkg::VEC_W-1:0]  x_out,
  output logic signed [lik_pkg::VEC_W-1:0]  y_out,
  output logic signed [lik_pkg::ACC_W-1:0]  a_out
);

  logic signed [lik_pkg::VEC_W-1:0] dx;
  logic signed [lik_pkg::VEC_W-1:0] dy;
  logic signed [lik_pkg::ACC_W-1:0] da;
  logic                             up;

  assign dx = x_in >>> stage;
  assign dy = y_in >>> stage;
  assign da = lik_pkg::atan_q30(stage);
  assign up = !y_in[lik_pkg::VEC_W-1] && (y_in != '0);

  // rotate toward the x axis, accumulate the angle taken
  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= up ? x_in + dy : x_in - dy;
      y_out <= up ? y_in - dx : y_in + dx;
      a_out <= up ? a_in + da : a_in - da;
    end
  end

endmodule

FILE: src/lik_vec_angle.sv
module lik_vec_angle (
  input  logic                              clk,
  input  logic                              en,
  input  logic [lik_pkg::VIN_W-1:0]         x,
  input  logic signed [lik_pkg::VIN_W:0]    y,
  output logic signed [lik_pkg::ACC_W-1:0]  ang
);

  logic [lik_pkg::VIN_W:0]          ay;
  logic [lik_pkg::VIN_W:0]          m;
  logic [lik_pkg::BL_W-1:0]         blen;

  logic [lik_pkg::VIN_W-1:0]        x1;
  logic signed [lik_pkg::VIN_W:0]   y1;
  logic [lik_pkg::BL_W-1:0]         b1;
  logic                             z1;

  logic signed [lik_pkg::VIN_W:0]   xs;
  logic [lik_pkg::BL_W-1:0]         lsh;
  logic [lik_pkg::BL_W-1:0]         rsh;

  logic signed [lik_pkg::VEC_W-1:0] x_w [lik_pkg::CORDIC_STAGES+1];
  logic signed [lik_pkg::VEC_W-1:0] y_w [lik_pkg::CORDIC_STAGES+1];
  logic signed [lik_pkg::ACC_W-1:0] a_w [lik_pkg::CORDIC_STAGES+1];
  logic                             zd  [lik_pkg::CORDIC_STAGES+1];

  // find the bit length of the larger component
  always_comb begin
    ay   = y[lik_pkg::VIN_W] ? -y : y;
    m    = ({1'b0, x} > ay) ? {1'b0, x} : ay;
    blen = '0;
    for (int i = 0; i <= lik_pkg::VIN_W; i++) begin
      if (m[i]) blen = lik_pkg::BL_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= x;
      y1 <= y;
      b1 <= blen;
      z1 <= (m == '0);
    end
  end

  // normalize so the larger component has NORM_BIT bits
  assign xs  = $signed({1'b0, x1});
  assign lsh = lik_pkg::BL_W'(lik_pkg::NORM_BIT) - b1;
  assign rsh = b1 - lik_pkg::BL_W'(lik_pkg::NORM_BIT);

  always_ff @(posedge clk) begin
    if (en) begin
      if (b1 < lik_pkg::BL_W'(lik_pkg::NORM_BIT)) begin
        x_w[0] <= lik_pkg::VEC_W'(xs <<< lsh);
        y_w[0] <= lik_pkg::VEC_W'(y1 <<< lsh);
      end else begin
        x_w[0] <= lik_pkg::VEC_W'(xs >>> rsh);
        y_w[0] <= lik_pkg::VEC_W'(y1 >>> rsh);
      end
      zd[0] <= z1;
      for (int i = 1; i <= lik_pkg::CORDIC_STAGES; i++) zd[i] <= zd[i-1];
    end
  end

  assign a_w[0] = '0;

  genvar g;
  for (g = 0; g < lik_pkg::CORDIC_STAGES; g++) begin : g_stage
    lik_cordic_cell u_cell (
      .clk   (clk),
      .en    (en),
      .stage (lik_pkg::STG_W'(g)),
      .x_in  (x_w[g]),
      .y_in  (y_w[g]),
      .a_in  (a_w[g]),
      .x_out (x_w[g+1]),
      .y_out (y_w[g+1]),
      .a_out (a_w[g+1])
    );
  end

  // a null vector has angle zero
  assign ang = zd[lik_pkg::CORDIC_STAGES] ? '0 : a_w[lik_pkg::CORDIC_STAGES];

endmodule

FILE: src/leg_inverse_kinematics_3dof.sv
// A result beat passes the front end, the square-root chains, the angle units and the output register.
// Throughput: one point per cycle while the skid slot is empty; the cell chains take a beat each such cycle.
// The pipeline is built from two 30-cell square-root chains and the 18-stage angle units.
// The whole pipeline holds while the two-entry output buffer is full.
// Reset (rst, synchronous) clears the pipeline valids and output buffer and loads the
// link registers with 800, 1360, 880 and -224 (1/16 mm).
module leg_inverse_kinematics_3dof (
  input logic        clk,
  input logic        rst,
  lik_pnt_if.sink    pnt,
  lik_ang_if.source  ang,
  lik_cfg_if.sink    cfg
);

  localparam int LAT = 3 + lik_pkg::SQ_STEPS + 7 + lik_pkg::SQ_STEPS + 1
                       + lik_pkg::VEC_LAT + 1;

  // Per-point context that rides along the pipeline
  typedef struct packed {
    logic               org;
    logic               flat;
    logic               degen;
    logic               zneg;
    logic               h3z;
    logic               unreach;
    logic               nneg;
    logic signed [17:0] zp;
    logic [16:0]        hx;
    logic signed [17:0] hy;
    logic [24:0]        gx;
    logic [24:0]        gy;
    logic [29:0]        nmag;
    logic [44:0]        bx;
  } ctx_t;

  // ---------------------------------------------------------------------------
  // Link registers and values derived from them. Config must change only while the
  // block is idle (the block does not enforce this), so derived registers settle before use.
  // ---------------------------------------------------------------------------
  logic [lik_pkg::LEN_W-1:0]        hk;
  logic [lik_pkg::LEN_W-1:0]        kf;
  logic [lik_pkg::LEN_W-1:0]        fe;
  logic signed [lik_pkg::LEN_W-1:0] ko;

  logic [27:0] hk2;
  logic [27:0] fe2;
  logic [27:0] kf2;
  logic [27:0] fk;
  logic [28:0] sumsq;
  logic [3:0]  sh;
  logic [29:0] dn;
  logic [43:0] kfdn;
  logic [44:0] dg;
  logic [4:0]  fkb;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hk <= lik_pkg::HK_RST;
      kf <= lik_pkg::KF_RST;
      fe <= lik_pkg::FE_RST;
      ko <= lik_pkg::KO_RST;
    end else if (cfg.valid) begin
      case (lik_pkg::cfg_reg_t'(cfg.index))
        lik_pkg::REG_HIP_KNEE:  hk <= cfg.data;
        lik_pkg::REG_KNEE_FOOT: kf <= cfg.data;
        lik_pkg::REG_FOOT_TIP:  fe <= cfg.data;
        lik_pkg::REG_KNEE_OFS:  ko <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // D = 2*FE*KF scaled by 2^16; shift D and N together until D fits 30 bits
  assign dg = {fk, 17'b0};

  always_comb begin
    fkb = '0;
    for (int i = 0; i < 28; i++) begin
      if (fk[i]) fkb = 5'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    hk2   <= hk * hk;
    fe2   <= fe * fe;
    kf2   <= kf * kf;
    fk    <= fe * kf;
    sumsq <= {1'b0, fe2} + {1'b0, kf2};
    sh    <= (fkb > 5'd13) ? 4'(fkb - 5'd13) : 4'd0;
    dn    <= 30'(dg >> sh);
    kfdn  <= kf * dn;
  end

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances together while the skid slot is empty.
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld;
  logic           ov;
  logic           sv;
  lik_pkg::res_t  od;
  lik_pkg::res_t  sd;
  lik_pkg::res_t  res_new;
  logic           push;
  logic           pop;

  assign en        = !sv;
  assign pnt.ready = en;
  assign push      = en && vld[LAT-1];
  assign pop       = ov && ang.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pnt.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: planar distance squared, knee-relative height, hip vector
  // ---------------------------------------------------------------------------
  logic signed [lik_pkg::COORD_W-1:0] px;
  logic signed [lik_pkg::COORD_W-1:0] py;
  logic signed [lik_pkg::COORD_W-1:0] pz;

  always_ff @(posedge clk) begin
    if (en) begin
      px <= pnt.x_pos;
      py <= pnt.y_pos;
      pz <= pnt.z_pos;
    end
  end

  logic signed [16:0] pxe;
  logic signed [17:0] pye;
  logic [16:0]        ax;
  logic [16:0]        ay;
  logic [30:0]        axx;
  logic [30:0]        ayy;
  logic signed [17:0] zp1;
  logic [16:0]        hx1;
  logic signed [17:0] hy1;
  logic               org1;

  assign pxe = 17'(px);
  assign pye = 18'(py);
  assign ax  = pxe[16] ? 17'(-pxe) : 17'(pxe);
  assign ay  = pye[17] ? 17'(-pye) : 17'(pye);

  always_ff @(posedge clk) begin
    if (en) begin
      axx  <= 31'(ax * ax);
      ayy  <= 31'(ay * ay);
      zp1  <= 18'(pz) - 18'(ko);
      hx1  <= ax;
      // fold the hip vector into the right half plane
      hy1  <= px[lik_pkg::COORD_W-1] ? -pye : pye;
      org1 <= (px == '0) && (py == '0);
    end
  end

  logic [31:0] hsq_c;
  logic [31:0] hsq;
  ctx_t        ctx_s2;
  ctx_t        ctx_s2_next;

  assign hsq_c = {1'b0, axx} + {1'b0, ayy};

  always_comb begin
    ctx_s2_next       = '0;
    ctx_s2_next.org   = org1;
    ctx_s2_next.flat  = (zp1 == '0) && (hsq_c > {4'b0, hk2});
    ctx_s2_next.degen = (zp1 == '0) && (hsq_c == {4'b0, hk2});
    ctx_s2_next.zneg  = zp1[17];
    ctx_s2_next.zp    = zp1;
    ctx_s2_next.hx    = hx1;
    ctx_s2_next.hy    = hy1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hsq    <= hsq_c;
      ctx_s2 <= ctx_s2_next;
    end
  end

  // ---------------------------------------------------------------------------
  // h = isqrt(hsq * 2^16) through the first square-root chain
  // ---------------------------------------------------------------------------
  logic [lik_pkg::SQ_OUT_W-1:0] root_a;
  ctx_t                         da [lik_pkg::SQ_STEPS];

  lik_isqrt u_sqrt_h (
    .clk  (clk),
    .en   (en),
    .rad  ({12'b0, hsq, 16'b0}),
    .root (root_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      da[0] <= ctx_s2;
      for (int i = 1; i < lik_pkg::SQ_STEPS; i++) da[i] <= da[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Reach geometry: h2, z', h3^2, N and the reach test
  // ---------------------------------------------------------------------------
  logic signed [25:0] h2g;
  logic signed [25:0] zg;
  ctx_t               ctx_a1;

  always_ff @(posedge clk) begin
    if (en) begin
      h2g    <= $signed({2'b00, root_a[23:0]}) - $signed({4'b0, hk, 8'b0});
      zg     <= {da[lik_pkg::SQ_STEPS-1].zp, 8'b0};
      ctx_a1 <= da[lik_pkg::SQ_STEPS-1];
    end
  end

  logic signed [51:0] h2p;
  logic signed [51:0] zgp;
  logic [47:0]        h2sq;
  logic [47:0]        zsq;
  ctx_t               ctx_a2;
  ctx_t               ctx_a2_next;

  assign h2p = h2g * h2g;
  assign zgp = zg * zg;

  always_comb begin
    ctx_a2_next    = ctx_a1;
    ctx_a2_next.gx = h2g[25] ? 25'(-h2g) : h2g[24:0];
    ctx_a2_next.gy = zg[25] ? 25'(-zg) : zg[24:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2sq   <= h2p[47:0];
      zsq    <= zgp[47:0];
      ctx_a2 <= ctx_a2_next;
    end
  end

  logic [48:0] h3sq;
  ctx_t        ctx_a3;

  always_ff @(posedge clk) begin
    if (en) begin
      h3sq   <= {1'b0, h2sq} + {1'b0, zsq};
      ctx_a3 <= ctx_a2;
    end
  end

  logic signed [50:0] ng;
  ctx_t               ctx_a4;
  ctx_t               ctx_a4_next;

  always_comb begin
    ctx_a4_next     = ctx_a3;
    ctx_a4_next.h3z = (h3sq == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng     <= $signed({6'b0, sumsq, 16'b0}) - $signed({2'b0, h3sq});
      ctx_a4 <= ctx_a4_next;
    end
  end

  logic [49:0] absng;
  ctx_t        ctx_a5;
  ctx_t        ctx_a5_next;

  assign absng = ng[50] ? 50'(-ng) : ng[49:0];

  always_comb begin
    ctx_a5_next         = ctx_a4;
    ctx_a5_next.unreach = (absng > {5'b0, dg});
    ctx_a5_next.nmag    = 30'(absng >> sh);
    ctx_a5_next.nneg    = ng[50];
  end

  always_ff @(posedge clk) begin
    if (en) ctx_a5 <= ctx_a5_next;
  end

  // ---------------------------------------------------------------------------
  // S^2 = (D-N)(D+N) and the law-of-sines vector x = |KF*D - FE*N|
  // ---------------------------------------------------------------------------
  logic signed [30:0] nn;
  logic signed [31:0] dn32;
  logic signed [31:0] am_c;
  logic signed [31:0] ap_c;
  logic signed [45:0] fenn_c;
  logic [30:0]        am;
  logic [30:0]        ap;
  logic signed [45:0] fenn;
  ctx_t               ctx_a6;

  assign nn     = ctx_a5.nneg ? -$signed({1'b0, ctx_a5.nmag}) : $signed({1'b0, ctx_a5.nmag});
  assign dn32   = $signed({2'b0, dn});
  assign am_c   = dn32 - 32'(nn);
  assign ap_c   = dn32 + 32'(nn);
  assign fenn_c = $signed({1'b0, fe}) * nn;

  always_ff @(posedge clk) begin
    if (en) begin
      am     <= am_c[30:0];
      ap     <= ap_c[30:0];
      fenn   <= fenn_c;
      ctx_a6 <= ctx_a5;
    end
  end

  logic [61:0]        prod_c;
  logic signed [46:0] bxd;
  logic [59:0]        prod;
  ctx_t               ctx_a7;
  ctx_t               ctx_a7_next;

  assign prod_c = am * ap;
  assign bxd    = $signed({3'b0, kfdn}) - fenn;

  always_comb begin
    ctx_a7_next    = ctx_a6;
    ctx_a7_next.bx = bxd[46] ? 45'(-bxd) : bxd[44:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= prod_c[59:0];
      ctx_a7 <= ctx_a7_next;
    end
  end

  // ---------------------------------------------------------------------------
  // S = isqrt((D-N)(D+N)) through the second square-root chain
  // ---------------------------------------------------------------------------
  logic [lik_pkg::SQ_OUT_W-1:0] root_b;
  ctx_t                         db [lik_pkg::SQ_STEPS];

  lik_isqrt u_sqrt_s (
    .clk  (clk),
    .en   (en),
    .rad  (prod),
    .root (root_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      db[0] <= ctx_a7;
      for (int i = 1; i < lik_pkg::SQ_STEPS; i++) db[i] <= db[i-1];
    end
  end

  logic [29:0] sn;
  logic [43:0] fesn;
  ctx_t        ctx_b1;

  always_ff @(posedge clk) begin
    if (en) begin
      sn     <= root_b;
      fesn   <= fe * root_b;
      ctx_b1 <= db[lik_pkg::SQ_STEPS-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Four angle units in parallel: hip, alpha, beta, gamma
  // ---------------------------------------------------------------------------
  logic signed [lik_pkg::ACC_W-1:0] hip_a;
  logic signed [lik_pkg::ACC_W-1:0] alpha_a;
  logic signed [lik_pkg::ACC_W-1:0] beta_a;
  logic signed [lik_pkg::ACC_W-1:0] gamma_a;
  ctx_t                             dc [lik_pkg::VEC_LAT];

  lik_vec_angle u_ang_hip (
    .clk (clk),
    .en  (en),
    .x   ({28'b0, ctx_b1.hx}),
    .y   ({{28{ctx_b1.hy[17]}}, ctx_b1.hy}),
    .ang (hip_a)
  );

  lik_vec_angle u_ang_alpha (
    .clk (clk),
    .en  (en),
    .x   ({15'b0, ctx_b1.nmag}),
    .y   ({16'b0, sn}),
    .ang (alpha_a)
  );

  lik_vec_angle u_ang_beta (
    .clk (clk),
    .en  (en),
    .x   (ctx_b1.bx),
    .y   ({2'b0, fesn}),
    .ang (beta_a)
  );

  lik_vec_angle u_ang_gamma (
    .clk (clk),
    .en  (en),
    .x   ({20'b0, ctx_b1.gx}),
    .y   ({21'b0, ctx_b1.gy}),
    .ang (gamma_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dc[0] <= ctx_b1;
      for (int i = 1; i < lik_pkg::VEC_LAT; i++) dc[i] <= dc[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Joint angles: foot = pi - alpha, knee from gamma and beta by the sign of z'
  // ---------------------------------------------------------------------------
  ctx_t                              cf;
  logic signed [lik_pkg::WIDE_W-1:0] al;
  logic signed [lik_pkg::WIDE_W-1:0] be;
  logic signed [lik_pkg::WIDE_W-1:0] ga;
  logic signed [lik_pkg::WIDE_W-1:0] al2;
  logic signed [lik_pkg::WIDE_W-1:0] hip_w;
  logic signed [lik_pkg::WIDE_W-1:0] knee_w;
  logic signed [lik_pkg::WIDE_W-1:0] foot_w;
  logic                              sol_w;

  assign cf  = dc[lik_pkg::VEC_LAT-1];
  assign al  = lik_pkg::WIDE_W'(alpha_a);
  assign be  = lik_pkg::WIDE_W'(beta_a);
  assign ga  = lik_pkg::WIDE_W'(gamma_a);
  assign al2 = cf.nneg ? lik_pkg::PI_Q30 - al : al;

  always_ff @(posedge clk) begin
    if (en) begin
      hip_w <= lik_pkg::WIDE_W'(hip_a);
      if (cf.flat) begin
        // straight leg in the hip plane: no reach test
        knee_w <= '0;
        foot_w <= '0;
      end else begin
        knee_w <= cf.zneg ? ga - be : -(ga + be);
        foot_w <= lik_pkg::PI_Q30 - al2;
      end
      sol_w <= !cf.org && (cf.flat || !(cf.degen || cf.h3z || cf.unreach));
    end
  end

  always_comb begin
    res_new.solved     = sol_w;
    res_new.hip_angle  = sol_w ? lik_pkg::to_out(hip_w) : '0;
    res_new.knee_angle = sol_w ? lik_pkg::to_out(knee_w) : '0;
    res_new.foot_angle = sol_w ? lik_pkg::to_out(foot_w) : '0;
  end

  // ---------------------------------------------------------------------------
  // Output buffer: output register plus one skid slot. A new beat lands in the
  // output register when it is free or draining, else in the skid slot.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (pop) sv <= 1'b0;
    end else if (push) begin
      if (ov && !pop) sv <= 1'b1;
      ov <= 1'b1;
    end else if (pop) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (pop) od <= sd;
    end else if (push) begin
      if (ov && !pop) sd <= res_new;
      else od <= res_new;
    end
  end

  assign ang.valid      = ov;
  assign ang.hip_angle  = od.hip_angle;
  assign ang.knee_angle = od.knee_angle;
  assign ang.foot_angle = od.foot_angle;
  assign ang.solved     = od.solved;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid slot holds a beat while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    sv && !ang.ready |=> sv && $stable(sd))
    else $error("skid beat lost while the output is stalled");

  a_push_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && ov && !ang.ready |=> sv)
    else $error("finished beat dropped on a stalled output");

  a_unsolved_zero: assert property (@(posedge clk) disable iff (rst)
    ang.valid && !ang.solved |->
      ang.hip_angle == '0 && ang.knee_angle == '0 && ang.foot_angle == '0)
    else $error("unsolved beat carries nonzero angles");

endmodule

FILE: tb/lik_tb_if.sv
`timescale 1ns / 100ps

// Row type for the directed stimulus table
package lik_tb_pkg;

  typedef struct {
    logic signed [lik_pkg::COORD_W-1:0] x;
    logic signed [lik_pkg::COORD_W-1:0] y;
    logic signed [lik_pkg::COORD_W-1:0] z;
    bit                                 known;
    lik_pkg::res_t                      res;
  } pnt_row_t;

endpackage

FILE: tb/leg_inverse_kinematics_3dof_test.sv
`timescale 1ns / 100ps

module leg_inverse_kinematics_3dof_test;

  localparam int LATENCY   = 90;
  localparam int WD_LIMIT  = 2000;
  localparam int N_RANDOM  = 500;
  localparam int CALM_TAIL = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lik_pnt_if pnt ();
  lik_ang_if ang ();
  lik_cfg_if cfg ();

  leg_inverse_kinematics_3dof DUT (
    .clk(clk), .rst(rst), .pnt(pnt.sink), .ang(ang.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Link lengths as the solver sees them.
  logic [lik_pkg::LEN_W-1:0]        hk_len, kf_len, fe_len;
  logic signed [lik_pkg::LEN_W-1:0] ko_ofs;

  lik_pkg::res_t pending_angles[$];
  int            errors = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  bit            calm = 1'b0;
  bit            sink_stall_en = 1'b1;

  // --------------------------------------------------------------------------
  // Angle predictor
  // --------------------------------------------------------------------------
  function automatic int bitlen(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  // Floor shift that rounds toward minus infinity, as the datapath does.
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_tbl(int i);
    longint t[16] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};
    return t[i];
  endfunction

  // Vectoring rotation: angle of (vx, vy) with vx >= 0, Q30 radians.
  function automatic longint vector_angle(longint vx, longint vy);
    longint m, acc, dx, dy;
    int b;
    m = (vy < 0) ? -vy : vy;
    acc = 0;
    if (vx > m) m = vx;
    if (m == 0) return 0;
    b = bitlen(m);
    if (b < lik_pkg::NORM_BIT) begin
      vx = vx <<< (lik_pkg::NORM_BIT - b);
      vy = vy <<< (lik_pkg::NORM_BIT - b);
    end else begin
      vx = floor_shr(vx, b - lik_pkg::NORM_BIT);
      vy = floor_shr(vy, b - lik_pkg::NORM_BIT);
    end
    for (int i = 0; i < lik_pkg::CORDIC_STAGES; i++) begin
      dx = floor_shr(vx, i);
      dy = floor_shr(vy, i);
      if (vy > 0) begin
        vx += dy;
        vy -= dx;
        acc += atan_tbl(i);
      end else begin
        vx -= dy;
        vy += dx;
        acc -= atan_tbl(i);
      end
    end
    return acc;
  endfunction

  function automatic logic signed [lik_pkg::ANG_W-1:0] round_angle(longint v);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r = (mag + (64'd1 << (lik_pkg::OUT_SHIFT - 1))) >>> lik_pkg::OUT_SHIFT;
    if (v < 0) r = -r;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[lik_pkg::ANG_W-1:0];
  endfunction

  function automatic lik_pkg::res_t solve_leg(logic signed [lik_pkg::COORD_W-1:0] px,
                                              logic signed [lik_pkg::COORD_W-1:0] py,
                                              logic signed [lik_pkg::COORD_W-1:0] pz);
    lik_pkg::res_t   r;
    longint          sx, sy, hk, kf, fe, zp, hip, knee, foot;
    longint          hg, h2g, zg, h3sq, ng, dg, dn, nn, sn, bx, alpha, beta, gam;
    longint unsigned hsq, hk2, nmag;
    int              b, sh;
    r = '0;
    sx = longint'(px);
    sy = longint'(py);
    hk = longint'(hk_len);
    kf = longint'(kf_len);
    fe = longint'(fe_len);
    zp = longint'(pz) - longint'(ko_ofs);
    knee = 0;
    foot = 0;
    hsq = sx * sx + sy * sy;
    hk2 = hk * hk;
    if (sx == 0 && sy == 0) return r;
    hip = (sx < 0) ? vector_angle(-sx, -sy) : vector_angle(sx, sy);
    // Flat straight reach skips the triangle entirely.
    if (!(zp == 0 && hsq > hk2)) begin
      if (zp == 0 && hsq == hk2) return r;
      if (hsq > (64'd1 << 32) || zp > 65536 || zp < -65536) return r;
      hg = sqrt_floor(hsq << 16);
      h2g = hg - hk * 256;
      zg = zp * 256;
      h3sq = h2g * h2g + zg * zg;
      if (h3sq == 0) return r;
      ng = (fe * fe + kf * kf) * 65536 - h3sq;
      dg = 2 * fe * kf * 65536;
      if (ng > dg || ng < -dg) return r;
      b = bitlen(dg);
      sh = (b > 30) ? b - 30 : 0;
      dn = dg >>> sh;
      nmag = ((ng < 0) ? -ng : ng) >> sh;
      nn = (ng < 0) ? -longint'(nmag) : longint'(nmag);
      sn = sqrt_floor(longint'(dn - nn) * longint'(dn + nn));
      alpha = vector_angle(nmag, sn);
      if (ng < 0) alpha = longint'(lik_pkg::PI_Q30) - alpha;
      bx = kf * dn - fe * nn;
      if (bx < 0) bx = -bx;
      beta = vector_angle(bx, fe * sn);
      gam = vector_angle((h2g < 0) ? -h2g : h2g, (zg < 0) ? -zg : zg);
      knee = (zp < 0) ? gam - beta : -(gam + beta);
      foot = longint'(lik_pkg::PI_Q30) - alpha;
    end
    r.hip_angle  = round_angle(hip);
    r.knee_angle = round_angle(knee);
    r.foot_angle = round_angle(foot);
    r.solved     = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: backpressure in bursts, compare each beat against the oldest
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      ang.ready  <= 1'b0;
      stall_left <= 0;
    end else if (calm || !sink_stall_en) begin
      ang.ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      ang.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      ang.ready  <= 1'b0;
      stall_left <= int'($urandom_range(0, 9));
    end else begin
      ang.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lik_pkg::res_t want;
    if (!rst && ang.valid && ang.ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected angle beat");
        errors++;
      end else begin
        want = pending_angles.pop_front();
        if (ang.hip_angle !== want.hip_angle) begin
          $error("hip_angle: expected %0d, got %0d", want.hip_angle, ang.hip_angle);
          errors++;
        end
        if (ang.knee_angle !== want.knee_angle) begin
          $error("knee_angle: expected %0d, got %0d", want.knee_angle, ang.knee_angle);
          errors++;
        end
        if (ang.foot_angle !== want.foot_angle) begin
          $error("foot_angle: expected %0d, got %0d", want.foot_angle, ang.foot_angle);
          errors++;
        end
        if (ang.solved !== want.solved) begin
          $error("solved: expected %0b, got %0b", want.solved, ang.solved);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((pnt.valid && pnt.ready) || (ang.valid && ang.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(lik_pkg::cfg_reg_t idx, logic [lik_pkg::LEN_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      lik_pkg::REG_HIP_KNEE:  hk_len = val;
      lik_pkg::REG_KNEE_FOOT: kf_len = val;
      lik_pkg::REG_FOOT_TIP:  fe_len = val;
      lik_pkg::REG_KNEE_OFS:  ko_ofs = $signed(val);
      default: ;
    endcase
  endtask

  // Drop valid for a gap now and then, unless the tail is calm.
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      pnt.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Send one point; known rows carry a hand-read answer, the rest go to the predictor.
  task automatic send_point(lik_tb_pkg::pnt_row_t row);
    lik_pkg::res_t want;
    maybe_gap();
    pnt.valid <= 1'b1;
    pnt.x_pos <= row.x;
    pnt.y_pos <= row.y;
    pnt.z_pos <= row.z;
    @(posedge clk);
    while (!pnt.ready) @(posedge clk);
    want = row.known ? row.res : solve_leg(row.x, row.y, row.z);
    pending_angles.push_back(want);
  endtask

  task automatic drain();
    pnt.valid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic lik_tb_pkg::pnt_row_t row(int x, int y, int z, bit known = 1'b0,
                                               lik_pkg::res_t r = '0);
    lik_tb_pkg::pnt_row_t p;
    p.x = lik_pkg::COORD_W'(x);
    p.y = lik_pkg::COORD_W'(y);
    p.z = lik_pkg::COORD_W'(z);
    p.known = known;
    p.res = r;
    return p;
  endfunction

  // Random point: mostly reachable targets near the working envelope.
  function automatic lik_tb_pkg::pnt_row_t rand_point();
    int reach;
    reach = int'(hk_len) + int'(kf_len) + int'(fe_len);
    case ($urandom_range(0, 9))
      0: return row(int'($urandom), int'($urandom), int'($urandom));
      1: return row(0, 0, int'($urandom));
      2: return row($urandom_range(0, 1) ? 32767 : -32768,
                    $urandom_range(0, 1) ? 32767 : -32768, int'($urandom));
      default:
        return row(int'($urandom_range(0, 2 * reach)) - reach,
                   int'($urandom_range(0, 2 * reach)) - reach,
                   int'(ko_ofs) + int'($urandom_range(0, 2 * reach)) - reach);
    endcase
  endfunction

  lik_tb_pkg::pnt_row_t directed[$];

  initial begin
    pnt.valid = 1'b0;
    pnt.x_pos = '0;
    pnt.y_pos = '0;
    pnt.z_pos = '0;
    cfg.valid = 1'b0;
    cfg.index = lik_pkg::REG_HIP_KNEE;
    cfg.data  = '0;
    hk_len = lik_pkg::HK_RST;
    kf_len = lik_pkg::KF_RST;
    fe_len = lik_pkg::FE_RST;
    ko_ofs = lik_pkg::KO_RST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table on the reset lengths. Rows marked known (origin, far-off, zero reach) are unsolved.
    directed = '{
      row(0, 0, 0, 1'b1, '0),
      row(0, 0, 32767, 1'b1, '0),
      row(32767, 32767, 0, 1'b1, '0),
      row(-32768, -32768, -32768, 1'b1, '0),
      row(0, 0, -32768, 1'b1, '0),
      row(800, 0, -224, 1'b1, '0),       // zero reach
      row(1500, 0, -224),                // flat straight
      row(1500, 0, -800),
      row(1500, 0, 400),
      row(-1500, 200, -600),
      row(0, 1600, -700),
      row(0, -1600, -700),
      row(-1, -1, 0),
      row(1, 0, -1000),
      row(32767, 0, -224),
      row(-32768, 0, -224),
      row(1200, -900, 300),
      row(2000, 1000, -1500),
      row(100, 100, -2000)
    };
    foreach (directed[i]) send_point(directed[i]);

    // Wait for everything to drain before reconfiguring.
    drain();

    // Extreme link settings, then back to a usual one.
    write_reg(lik_pkg::REG_HIP_KNEE, 14'd1);
    write_reg(lik_pkg::REG_KNEE_FOOT, 14'd16383);
    write_reg(lik_pkg::REG_FOOT_TIP, 14'd16383);
    write_reg(lik_pkg::REG_KNEE_OFS, 14'h2000);
    for (int i = 0; i < N_RANDOM / 4; i++) send_point(rand_point());
    drain();

    write_reg(lik_pkg::REG_HIP_KNEE, 14'd16383);
    write_reg(lik_pkg::REG_KNEE_FOOT, 14'd1);
    write_reg(lik_pkg::REG_FOOT_TIP, 14'd1);
    write_reg(lik_pkg::REG_KNEE_OFS, 14'h1FFF);
    for (int i = 0; i < N_RANDOM / 4; i++) send_point(rand_point());
    drain();

    write_reg(lik_pkg::REG_HIP_KNEE, lik_pkg::LEN_W'($urandom_range(200, 3000)));
    write_reg(lik_pkg::REG_KNEE_FOOT, lik_pkg::LEN_W'($urandom_range(200, 3000)));
    write_reg(lik_pkg::REG_FOOT_TIP, lik_pkg::LEN_W'($urandom_range(200, 3000)));
    write_reg(lik_pkg::REG_KNEE_OFS, lik_pkg::LEN_W'($urandom_range(0, 1023) - 512));
    for (int i = 0; i < N_RANDOM / 2 - CALM_TAIL; i++) send_point(rand_point());

    // Tail with no idling on either side.
    calm = 1'b1;
    for (int i = 0; i < CALM_TAIL; i++) send_point(rand_point());
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
